// ----- design/c8hfc_pkg.sv -----
// Shared types, constants and CRC/hex helper functions for the CRC-8 hex frame checker.
package c8hfc_pkg;

  localparam logic [7:0] CRC_POLY      = 8'h8C;  // reflected Dallas/Maxim polynomial
  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam logic [7:0] ASCII_NINE    = 8'd57;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;  // 'A' - 10
  localparam logic [7:0] NIB_LO_MASK   = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK   = 8'hF0;
  localparam logic [3:0] NIB_MAX_DEC   = 4'd9;

  localparam int unsigned OQ_DEPTH = 2;
  localparam logic [1:0]  OQ_FULL  = 2'(OQ_DEPTH);

  // Number of result transfers one input item causes.
  localparam logic [1:0] NRES_NONE  = 2'd0;
  localparam logic [1:0] NRES_CHECK = 2'd1;
  localparam logic [1:0] NRES_GEN   = 2'd2;

  typedef struct packed {
    logic [7:0] hex_char;
    logic       check_pass;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] n_res;       // result transfers caused by the presented item
    result_t    res0;        // first result
    result_t    res1;        // second result (generate mode only)
    logic       check_mode;  // current mode register
  } frm_out_t;

  // One byte through the LSB-first CRC-8, eight shift steps.
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Decimal digits give code - 48, everything else code - 55 (mod 256).
  function automatic logic [7:0] hex_digit_value(logic [7:0] ch);
    logic [7:0] v;
    if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
      v = ch - ASCII_ZERO;
    end else begin
      v = ch - HEX_ALPHA_OFS;
    end
    return v;
  endfunction

  function automatic logic [7:0] nibble_to_hex(logic [3:0] n);
    logic [7:0] v;
    if (n > NIB_MAX_DEC) begin
      v = {4'd0, n} + HEX_ALPHA_OFS;
    end else begin
      v = {4'd0, n} + ASCII_ZERO;
    end
    return v;
  endfunction

endpackage

// ----- design/c8hfc_frame.sv -----
// Frame state of the CRC-8 hex checker: running CRC, held trailer characters, mode register.
module c8hfc_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                fire_i,      // consume the presented character
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output c8hfc_pkg::frm_out_t frm_o
);
  import c8hfc_pkg::*;

  logic       mode_q, mode_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] held0_q, held0_d;
  logic [7:0] held1_q, held1_d;
  logic [1:0] cnt_q, cnt_d;

  logic       full_hold;
  logic [7:0] crc_gen;
  logic [7:0] crc_shift;   // CRC after the oldest held character
  logic [7:0] hi_val;
  logic [7:0] lo_val;
  logic [7:0] trl_byte;
  logic [7:0] crc_chk;

  assign full_hold = cnt_q[1];
  assign crc_gen   = crc8_update(crc_q, char_i);
  assign crc_shift = crc8_update(crc_q, held0_q);
  assign lo_val    = hex_digit_value(char_i);
  assign trl_byte  = ((hi_val << 4) & NIB_HI_MASK) | (lo_val & NIB_LO_MASK);
  assign crc_chk   = crc8_update(full_hold ? crc_shift : crc_q, trl_byte);

  always_comb begin
    if (full_hold) begin
      hi_val = hex_digit_value(held1_q);
    end else if (cnt_q[0]) begin
      hi_val = hex_digit_value(held0_q);
    end else begin
      hi_val = '0;
    end
  end

  always_comb begin
    frm_o.check_mode = mode_q;
    frm_o.res0       = '0;
    frm_o.res1       = '0;
    if (!last_i) begin
      frm_o.n_res = NRES_NONE;
    end else if (mode_q) begin
      frm_o.n_res            = NRES_CHECK;
      frm_o.res0.check_pass  = (crc_chk == 8'd0);
      frm_o.res0.last_result = 1'b1;
    end else begin
      frm_o.n_res            = NRES_GEN;
      frm_o.res0.hex_char    = nibble_to_hex(crc_gen[7:4]);
      frm_o.res1.hex_char    = nibble_to_hex(crc_gen[3:0]);
      frm_o.res1.last_result = 1'b1;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    crc_d   = crc_q;
    held0_d = held0_q;
    held1_d = held1_q;
    cnt_d   = cnt_q;
    if (cfg_we_i) begin
      mode_d  = cfg_wdata_i;
      crc_d   = '0;
      held0_d = '0;
      held1_d = '0;
      cnt_d   = '0;
    end else if (fire_i) begin
      if (last_i) begin
        crc_d   = '0;
        held0_d = '0;
        held1_d = '0;
        cnt_d   = '0;
      end else if (!mode_q) begin
        crc_d = crc_gen;
      end else if (full_hold) begin
        crc_d   = crc_shift;
        held0_d = held1_q;
        held1_d = char_i;
      end else if (cnt_q[0]) begin
        held1_d = char_i;
        cnt_d   = 2'd2;
      end else begin
        held0_d = char_i;
        cnt_d   = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      crc_q   <= '0;
      held0_q <= '0;
      held1_q <= '0;
      cnt_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      crc_q   <= crc_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      cnt_q   <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("held count out of range");

  a_gen_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> cnt_q == 2'd0)
    else $error("characters held in generate mode");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> crc_q == 8'd0 && cnt_q == 2'd0)
    else $error("frame state not cleared after last character");

endmodule

// ----- design/crc8_hex_frame_check.sv -----
// Top level of the CRC-8 (Dallas/Maxim) hex frame generator and checker.
// Characters enter as stream transfers, tlast on the final character of a frame.
// With cfg_wdata_i = 0 written (generate mode) every character goes through the
// CRC (reflected polynomial 0x8C, start 0) and the last one yields two result
// transfers: the CRC as uppercase ASCII hex, high digit first, tlast on the second.
// With 1 written (check mode) the last two characters of the frame are taken as a
// hex trailer; the frame's last character yields one transfer whose tuser bit says
// whether the CRC over message and decoded trailer is zero. Writing the mode drops
// any frame under way; write it only while the block is idle. Throughput is one
// character per cycle unless a final character waits for queue room: each is
// registered at the input and consumed in the following cycle by the CRC logic,
// which posts its results into a two-entry output queue. A final character is
// consumed only once the queue has room for all its results (two free entries in
// generate mode), so with tready held high a one-character generate frame that
// directly follows a generate-mode frame end waits until the earlier frame's second
// digit is taken. A final character's results show once it has fired into the queue.
module crc8_hex_frame_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: mode register
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,     // check_mode
  // character input
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_char
  input  logic       s_axis_tlast_i,  // last_char
  // result output
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] hex_char
  output logic       m_axis_tuser_o,  // [0] check_pass
  output logic       m_axis_tlast_o   // last_result
);
  import c8hfc_pkg::*;

  // input register
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // output queue, entry 0 is the head
  result_t    oq0_q, oq0_d;
  result_t    oq1_q, oq1_d;
  logic [1:0] oq_cnt_q, oq_cnt_d;

  frm_out_t   frm;
  logic       s_xfer;
  logic       pop;
  logic       fire;
  logic [1:0] oq_free;
  logic [1:0] oq_rem;     // entries left after this cycle's pop

  assign pop     = m_axis_tvalid_o && m_axis_tready_i;
  assign oq_rem  = oq_cnt_q - {1'b0, pop};
  assign oq_free = OQ_FULL - oq_rem;
  assign fire    = in_vld_q && (frm.n_res <= oq_free);

  // Take a new character when none is held or the held one is consumed this cycle.
  assign s_axis_tready_o = !in_vld_q || fire;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  c8hfc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .char_i      (in_char_q),
    .last_i      (in_last_q),
    .frm_o       (frm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  // Payload holds until the next transfer; no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Advance the queue: drop the popped head, then append the new results.
  always_comb begin
    logic [1:0] n_push;
    result_t    r0;
    n_push = fire ? frm.n_res : NRES_NONE;
    r0     = pop ? oq1_q : oq0_q;
    oq_cnt_d = oq_rem + n_push;
    case (oq_rem)
      2'd0: begin
        oq0_d = frm.res0;
        oq1_d = frm.res1;
      end
      2'd1: begin
        oq0_d = r0;
        oq1_d = frm.res0;
      end
      default: begin
        oq0_d = oq0_q;
        oq1_d = oq1_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oq0_q <= oq0_d;
    oq1_q <= oq1_d;
  end

  assign m_axis_tvalid_o = (oq_cnt_q != 2'd0);
  assign m_axis_tdata_o  = oq0_q.hex_char;
  assign m_axis_tuser_o  = oq0_q.check_pass;
  assign m_axis_tlast_o  = oq0_q.last_result;

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= OQ_FULL)
    else $error("output queue overflow");

  a_gen_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q && !frm.check_mode |=> oq_cnt_q == OQ_FULL && !oq0_q.last_result
      && oq1_q.last_result)
    else $error("generate-mode digit pair not queued");

  a_check_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q && frm.check_mode |=> oq_cnt_q != 2'd0 && m_axis_tvalid_o)
    else $error("check-mode result not queued");

endmodule
